// File: rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int BLOCK_WORDS_DEFAULT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_word;
        logic load_pad;
        logic start_block;
        logic do_round;
        logic fold;
        logic restart;
        logic emit_shift;
    } ctrl_t;

    typedef struct packed {
        logic block_full;
        logic last_slot;
        logic rounds_done;
        logic pad_done;
    } status_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_BYTE = 32'h00000080;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] v);
        ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] v);
        ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] v);
        bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] v);
        bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

endpackage

// File: rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer for word intake, padding, the 64 rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl
    import sha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    out_final,
    output logic [2:0] out_index,
    input  status_t status,
    output ctrl_t   ctrl
);

    state_t     state_reg, state_next;
    logic       final_reg, final_next;
    logic [2:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    final_next = in_last;
                    if (in_last)
                        state_next = ST_PAD;
                    else if (status.last_slot)
                        state_next = ST_ROUND;
                end
            end
            ST_PAD:
            begin
                if (status.block_full)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (status.rounds_done)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (status.pad_done)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
                else
                    state_next = ST_PAD;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        final_next = 1'b0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                ctrl.load_word = in_valid;
            end
            ST_PAD:
                ctrl.load_pad = 1'b1;
            ST_ROUND:
                ctrl.do_round = 1'b1;
            ST_FOLD:
                ctrl.fold = 1'b1;
            ST_EMIT:
            begin
                out_valid       = 1'b1;
                ctrl.emit_shift = out_ready;
                ctrl.restart    = out_ready && (idx_reg == 3'd7);
            end
            default:
                ctrl = '0;
        endcase
        ctrl.start_block = (state_reg == ST_IDLE && in_valid && !in_last && status.last_slot)
                         || (state_reg == ST_PAD && status.block_full);
    end

    assign out_final = (idx_reg == 3'd7);
    assign out_index = idx_reg;

endmodule

// File: rtl/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Block buffer, padding, message schedule, round logic and chaining state.
// ----------------------------------------------------------------------------
module sha_dp
    import sha_pkg::*;
#(
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    input  ctrl_t       ctrl,
    output status_t     status,
    output logic [31:0] digest_word
);

    localparam int FW = $clog2(BLOCK_WORDS);

    logic [31:0] win_reg [BLOCK_WORDS];
    logic [31:0] hash_reg [8];
    logic [31:0] v_reg [8];
    logic [FW-1:0] fill_reg;
    logic [5:0]  rnd_reg;
    logic [63:0] len_reg;
    logic        pad_pend_reg;
    logic        len_pend_reg;
    logic        len_hi_reg;
    logic        blk_full_reg;

    logic [31:0] push_w;
    logic [2:0]  nb;
    logic [31:0] keep, marked;
    logic        push;
    logic        len_hi_push;
    logic        len_lo_push;
    logic [63:0] len_next;
    logic [31:0] w, s1, s2, ch, mj, sched;

    always_comb
    begin
        nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nb)
            3'd0: keep = 32'h00000000;
            3'd1: keep = 32'hff000000;
            3'd2: keep = 32'hffff0000;
            3'd3: keep = 32'hffffff00;
            default: keep = 32'hffffffff;
        endcase
        marked = (nb == 3'd4) ? data_word :
                 ((data_word & keep) | (PAD_BYTE << (5'd8 * (5'd3 - {2'b0, nb}))));
        len_next = len_reg + (last ? {58'd0, nb, 3'd0} : 64'd32);
        push        = 1'b0;
        push_w      = 32'h0;
        len_hi_push = 1'b0;
        len_lo_push = 1'b0;
        if (ctrl.load_word)
        begin
            push   = 1'b1;
            push_w = last ? marked : data_word;
        end
        else if (ctrl.load_pad && !blk_full_reg)
        begin
            push = 1'b1;
            if (pad_pend_reg)
                push_w = 32'h80000000;
            else if (len_pend_reg && fill_reg == FW'(BLOCK_WORDS - 2))
            begin
                push_w      = len_reg[63:32];
                len_hi_push = 1'b1;
            end
            else if (len_hi_reg && fill_reg == FW'(BLOCK_WORDS - 1))
            begin
                push_w      = len_reg[31:0];
                len_lo_push = 1'b1;
            end
        end
    end

    assign status.block_full  = blk_full_reg;
    assign status.last_slot   = (fill_reg == FW'(BLOCK_WORDS - 1));
    assign status.rounds_done = (rnd_reg == 6'd63);
    assign status.pad_done    = !len_pend_reg && !pad_pend_reg;

    assign w  = (rnd_reg < 6'd16) ? win_reg[0] : sched;
    assign sched = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign s1 = v_reg[7] + bsig1(v_reg[4]) + ch + ROUND_CONST[rnd_reg] + w;
    assign s2 = bsig0(v_reg[0]) + mj;

    always_ff @(posedge clk)
    begin
        if (push)
            win_reg[fill_reg] <= push_w;
        else if (ctrl.do_round)
        begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[BLOCK_WORDS - 1] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rnd_reg       <= '0;
            len_reg       <= '0;
            pad_pend_reg  <= 1'b0;
            len_pend_reg  <= 1'b0;
            len_hi_reg    <= 1'b0;
            blk_full_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= INIT_HASH[i];
                v_reg[i]    <= '0;
            end
        end
        else
        begin
            if (ctrl.load_word)
            begin
                len_reg <= len_next;
                if (last)
                begin
                    pad_pend_reg <= (nb == 3'd4);
                    len_pend_reg <= 1'b1;
                end
            end
            if (push)
            begin
                fill_reg <= fill_reg + FW'(1);
                if (fill_reg == FW'(BLOCK_WORDS - 1))
                    blk_full_reg <= 1'b1;
                if (ctrl.load_pad)
                    pad_pend_reg <= 1'b0;
                if (len_hi_push)
                    len_hi_reg <= 1'b1;
                if (len_lo_push)
                begin
                    len_hi_reg   <= 1'b0;
                    len_pend_reg <= 1'b0;
                end
            end
            if (ctrl.start_block)
            begin
                blk_full_reg <= 1'b0;
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= hash_reg[i];
            end
            if (ctrl.do_round)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + s1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= s1 + s2;
            end
            if (ctrl.fold)
            begin
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
            end
            if (ctrl.emit_shift)
            begin
                for (int i = 0; i < 7; i++)
                    hash_reg[i] <= hash_reg[i + 1];
                hash_reg[7] <= hash_reg[0];
            end
            if (ctrl.restart)
            begin
                len_reg <= '0;
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= INIT_HASH[i];
            end
        end
    end

    assign digest_word = hash_reg[0];

endmodule

// File: rtl/sha256_message_hasher_top.sv
// Words are buffered; a full block runs rounds and fold before input resumes.
// A last word is followed by padding, then rounds and fold per block (one or two).
// Throughput is set by the single round unit: 64 rounds per 16-word block.
// Digest words leave one per cycle while m_tready is high.
// rst_n clears all control state asynchronously and loads the initial hash.
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// SHA-256 hasher with stream input of message words and digest output.
// ----------------------------------------------------------------------------
module sha256_message_hasher_top
    import sha_pkg::*;
#(
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // data_word[31:0], valid_bytes[34:32], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
    output logic        m_tlast
);

    ctrl_t       ctrl;
    status_t     status;
    logic [31:0] digest;
    logic [2:0]  idx;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_final (m_tlast),
        .out_index (idx),
        .status    (status),
        .ctrl      (ctrl)
    );

    sha_dp #(.BLOCK_WORDS(BLOCK_WORDS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_word   (s_tdata[31:0]),
        .valid_bytes (s_tdata[34:32]),
        .last        (s_tlast),
        .ctrl        (ctrl),
        .status      (status),
        .digest_word (digest)
    );

    assign m_tdata = {5'd0, idx, digest};

endmodule

// File: rtl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of input/output overlap and the hasher's output sequencing.
// ----------------------------------------------------------------------------
module sha_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast,
    input logic [39:0] m_tdata
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input taken during output");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("tlast mismatch");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid
        && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)) else $error("index step");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))) else $error("hold");

endmodule

bind sha256_message_hasher_top sha_checker u_sha_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
);
